/* rtl/core/tiw_pkg.sv */
// ----------------------------------------------------------------------------
// tiw_pkg
// Shared types, widths and codes for the triangle inverse warp block.
// ----------------------------------------------------------------------------
`default_nettype none

package tiw_pkg;

    localparam int TIW_NUM_LANDMARKS = 128;
    localparam int TIW_FRAC_BITS     = 4;

    localparam int TIW_CW   = 16;              // landmark coordinate width
    localparam int TIW_PIXW = 12;              // pixel / origin width
    localparam int TIW_IDXW = 7;               // vertex index width
    localparam int TIW_DW   = TIW_CW + 1;      // signed coordinate difference
    localparam int TIW_DETW = 2 * TIW_DW + 1;  // determinant width

    // quotient bits: 12 result bits plus one overflow bit
    localparam int TIW_QBITS   = TIW_PIXW + 1;
    localparam int TIW_DIV_LAT = TIW_QBITS + 1;

    localparam logic [TIW_PIXW-1:0] TIW_COORD_MAX = '1;

    localparam logic TIW_REQ_LOAD  = 1'b0;
    localparam logic TIW_REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [TIW_CW-1:0] wx;
        logic [TIW_CW-1:0] wy;
        logic [TIW_CW-1:0] sx;
        logic [TIW_CW-1:0] sy;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic hit;
        logic degen;
    } t_tag;

    function automatic int tiw_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tiw_lmtab.sv */
// ----------------------------------------------------------------------------
// tiw_lmtab
// Landmark table copy: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tiw_lmtab #(
    parameter int NUM_LANDMARKS = tiw_pkg::TIW_NUM_LANDMARKS,
    parameter int AW            = $clog2(NUM_LANDMARKS)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire tiw_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output tiw_pkg::t_entry      o_rdata
);
    import tiw_pkg::*;

    t_entry r_mem [NUM_LANDMARKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/tiw_geom.sv */
// ----------------------------------------------------------------------------
// tiw_geom
// Five-stage geometry pipe: differences, products, determinant and edge
// tests, weighted source products, numerator sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tiw_geom #(
    parameter int FRAC_BITS = tiw_pkg::TIW_FRAC_BITS,
    parameter int PW  = tiw_pkg::TIW_PIXW + FRAC_BITS,
    parameter int BW  = tiw_pkg::tiw_max(PW, tiw_pkg::TIW_CW) + 1,
    parameter int NW  = tiw_pkg::TIW_DW + BW + 1,
    parameter int NXW = NW + tiw_pkg::TIW_DW + 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire tiw_pkg::t_entry               i_a,
    input  wire tiw_pkg::t_entry               i_b,
    input  wire tiw_pkg::t_entry               i_c,
    input  wire logic [tiw_pkg::TIW_PIXW-1:0]  i_px,
    input  wire logic [tiw_pkg::TIW_PIXW-1:0]  i_py,
    output logic signed [NXW-1:0]              o_nx,
    output logic signed [NXW-1:0]              o_ny,
    output logic signed [tiw_pkg::TIW_DETW-1:0] o_det,
    output tiw_pkg::t_tag                      o_tag
);
    import tiw_pkg::*;

    localparam int PRW = TIW_DW + BW;        // difference times pixel offset
    localparam int DPW = 2 * TIW_DW;         // difference times difference
    localparam int MW  = NW + TIW_DW;        // numerator times source diff
    localparam int CMW = TIW_DETW + TIW_DW;  // determinant times source

    // pixel scaled onto the landmark grid
    logic [PW-1:0] pxs, pys;
    assign pxs = PW'(i_px) << FRAC_BITS;
    assign pys = PW'(i_py) << FRAC_BITS;

    function automatic logic signed [TIW_DW-1:0] cdiff(input logic [TIW_CW-1:0] u,
                                                       input logic [TIW_CW-1:0] v);
        return $signed({1'b0, u}) - $signed({1'b0, v});
    endfunction

    function automatic logic signed [BW-1:0] pdiff(input logic [PW-1:0] p,
                                                   input logic [TIW_CW-1:0] v);
        return $signed({{(BW-PW){1'b0}}, p}) - $signed({{(BW-TIW_CW){1'b0}}, v});
    endfunction

    // stage 2: differences
    logic                     r2_valid;
    logic signed [TIW_DW-1:0] r2_a00, r2_a01, r2_a10, r2_a11;
    logic signed [BW-1:0]     r2_b0, r2_b1;
    logic signed [TIW_DW-1:0] r2_e0x, r2_e0y, r2_e1x, r2_e1y, r2_e2x, r2_e2y;
    logic signed [BW-1:0]     r2_d0x, r2_d0y, r2_d1x, r2_d1y;
    logic signed [TIW_DW-1:0] r2_sxa, r2_sxb, r2_sya, r2_syb;
    logic [TIW_CW-1:0]        r2_csx, r2_csy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= i_valid;
        end
        if (i_en) begin
            r2_a00 <= cdiff(i_a.wx, i_c.wx);
            r2_a01 <= cdiff(i_b.wx, i_c.wx);
            r2_a10 <= cdiff(i_a.wy, i_c.wy);
            r2_a11 <= cdiff(i_b.wy, i_c.wy);
            r2_b0  <= pdiff(pxs, i_c.wx);
            r2_b1  <= pdiff(pys, i_c.wy);
            r2_e0x <= cdiff(i_b.wx, i_a.wx);
            r2_e0y <= cdiff(i_b.wy, i_a.wy);
            r2_e1x <= cdiff(i_c.wx, i_b.wx);
            r2_e1y <= cdiff(i_c.wy, i_b.wy);
            r2_e2x <= cdiff(i_a.wx, i_c.wx);
            r2_e2y <= cdiff(i_a.wy, i_c.wy);
            r2_d0x <= pdiff(pxs, i_a.wx);
            r2_d0y <= pdiff(pys, i_a.wy);
            r2_d1x <= pdiff(pxs, i_b.wx);
            r2_d1y <= pdiff(pys, i_b.wy);
            r2_sxa <= cdiff(i_a.sx, i_c.sx);
            r2_sxb <= cdiff(i_b.sx, i_c.sx);
            r2_sya <= cdiff(i_a.sy, i_c.sy);
            r2_syb <= cdiff(i_b.sy, i_c.sy);
            r2_csx <= i_c.sx;
            r2_csy <= i_c.sy;
        end
    end

    // stage 3: products
    logic                     r3_valid;
    logic signed [DPW-1:0]    r3_pd1, r3_pd2;
    logic signed [PRW-1:0]    r3_n0a, r3_n0b, r3_n1a, r3_n1b;
    logic signed [PRW-1:0]    r3_c0a, r3_c0b, r3_c1a, r3_c1b, r3_c2a, r3_c2b;
    logic signed [TIW_DW-1:0] r3_sxa, r3_sxb, r3_sya, r3_syb;
    logic [TIW_CW-1:0]        r3_csx, r3_csy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_pd1 <= r2_a00 * r2_a11;
            r3_pd2 <= r2_a01 * r2_a10;
            r3_n0a <= r2_a11 * r2_b0;
            r3_n0b <= r2_a01 * r2_b1;
            r3_n1a <= r2_a00 * r2_b1;
            r3_n1b <= r2_a10 * r2_b0;
            r3_c0a <= r2_e0x * r2_d0y;
            r3_c0b <= r2_e0y * r2_d0x;
            r3_c1a <= r2_e1x * r2_d1y;
            r3_c1b <= r2_e1y * r2_d1x;
            r3_c2a <= r2_e2x * r2_b1;
            r3_c2b <= r2_e2y * r2_b0;
            r3_sxa <= r2_sxa;
            r3_sxb <= r2_sxb;
            r3_sya <= r2_sya;
            r3_syb <= r2_syb;
            r3_csx <= r2_csx;
            r3_csy <= r2_csy;
        end
    end

    // stage 4: determinant, numerators, edge signs
    logic signed [NW-1:0] cr0, cr1, cr2;
    logic                 f0, f1, f2;
    assign cr0 = NW'(r3_c0a) - NW'(r3_c0b);
    assign cr1 = NW'(r3_c1a) - NW'(r3_c1b);
    assign cr2 = NW'(r3_c2a) - NW'(r3_c2b);
    assign f0  = (cr0 > 0);
    assign f1  = (cr1 > 0);
    assign f2  = (cr2 > 0);

    logic                       r4_valid, r4_inside;
    logic signed [TIW_DETW-1:0] r4_det;
    logic signed [NW-1:0]       r4_n0, r4_n1;
    logic signed [TIW_DW-1:0]   r4_sxa, r4_sxb, r4_sya, r4_syb;
    logic [TIW_CW-1:0]          r4_csx, r4_csy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r4_inside <= (f0 & f1 & f2) | (~f0 & ~f1 & ~f2);
            r4_det    <= TIW_DETW'(r3_pd1) - TIW_DETW'(r3_pd2);
            r4_n0     <= NW'(r3_n0a) - NW'(r3_n0b);
            r4_n1     <= NW'(r3_n1a) - NW'(r3_n1b);
            r4_sxa    <= r3_sxa;
            r4_sxb    <= r3_sxb;
            r4_sya    <= r3_sya;
            r4_syb    <= r3_syb;
            r4_csx    <= r3_csx;
            r4_csy    <= r3_csy;
        end
    end

    // stage 5: weighted source products
    logic                       r5_valid, r5_inside;
    logic signed [TIW_DETW-1:0] r5_det;
    logic signed [MW-1:0]       r5_mx0, r5_mx1, r5_my0, r5_my1;
    logic signed [CMW-1:0]      r5_mx2, r5_my2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
        if (i_en) begin
            r5_inside <= r4_inside;
            r5_det    <= r4_det;
            r5_mx0    <= r4_n0 * r4_sxa;
            r5_mx1    <= r4_n1 * r4_sxb;
            r5_my0    <= r4_n0 * r4_sya;
            r5_my1    <= r4_n1 * r4_syb;
            r5_mx2    <= r4_det * $signed({1'b0, r4_csx});
            r5_my2    <= r4_det * $signed({1'b0, r4_csy});
        end
    end

    // stage 6: numerator sums
    logic                       r6_valid, r6_inside;
    logic signed [TIW_DETW-1:0] r6_det;
    logic signed [NXW-1:0]      r6_nx, r6_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= r5_valid;
        end
        if (i_en) begin
            r6_inside <= r5_inside;
            r6_det    <= r5_det;
            r6_nx     <= NXW'(r5_mx0) + NXW'(r5_mx1) + NXW'(r5_mx2);
            r6_ny     <= NXW'(r5_my0) + NXW'(r5_my1) + NXW'(r5_my2);
        end
    end

    assign o_nx        = r6_nx;
    assign o_ny        = r6_ny;
    assign o_det       = r6_det;
    assign o_tag.valid = r6_valid;
    assign o_tag.hit   = r6_inside;
    assign o_tag.degen = (r6_det == '0);

endmodule

`default_nettype wire

/* rtl/core/tiw_div.sv */
// ----------------------------------------------------------------------------
// tiw_div
// Pipelined restoring divider, one quotient bit per stage. Truncates toward
// zero and clamps the quotient to the image range.
// ----------------------------------------------------------------------------
`default_nettype none

module tiw_div #(
    parameter int FRAC_BITS = tiw_pkg::TIW_FRAC_BITS,
    parameter int NXW       = 54
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic signed [NXW-1:0]           i_num,
    input  wire logic signed [tiw_pkg::TIW_DETW-1:0] i_det,
    output logic [tiw_pkg::TIW_PIXW-1:0]         o_coord,
    output logic                                 o_clip
);
    import tiw_pkg::*;

    localparam int RW = tiw_max(NXW, TIW_DETW + FRAC_BITS + TIW_QBITS - 1) + 1;

    logic [RW-1:0]        r_rem [TIW_QBITS+1];
    logic [RW-1:0]        r_den [TIW_QBITS+1];
    logic [TIW_QBITS-1:0] r_q   [TIW_QBITS+1];
    logic                 r_neg [TIW_QBITS+1];

    logic [NXW-1:0]      num_mag;
    logic [TIW_DETW-1:0] det_mag;
    assign num_mag = i_num[NXW-1] ? NXW'(-i_num) : NXW'(i_num);
    assign det_mag = i_det[TIW_DETW-1] ? TIW_DETW'(-i_det) : TIW_DETW'(i_det);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(num_mag);
            r_den[0] <= RW'(det_mag) << FRAC_BITS;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[NXW-1] ^ i_det[TIW_DETW-1];
            for (int i = 0; i < TIW_QBITS; i++) begin
                if (r_rem[i] >= (r_den[i] << (TIW_QBITS - 1 - i))) begin
                    r_rem[i+1] <= r_rem[i] - (r_den[i] << (TIW_QBITS - 1 - i));
                    r_q[i+1]   <= r_q[i] | (TIW_QBITS'(1) << (TIW_QBITS - 1 - i));
                end else begin
                    r_rem[i+1] <= r_rem[i];
                    r_q[i+1]   <= r_q[i];
                end
                r_den[i+1] <= r_den[i];
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    // top quotient bit set: magnitude beyond the image
    logic [TIW_QBITS-1:0] q;
    assign q = r_q[TIW_QBITS];

    always_comb begin
        if (r_neg[TIW_QBITS]) begin
            o_coord = '0;
            o_clip  = (q != '0);
        end else if (q[TIW_QBITS-1]) begin
            o_coord = TIW_COORD_MAX;
            o_clip  = 1'b1;
        end else begin
            o_coord = q[TIW_PIXW-1:0];
            o_clip  = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/triangle_inverse_warp.sv */
// ----------------------------------------------------------------------------
// triangle_inverse_warp
// Landmark table with a barycentric inside test and inverse map per pixel.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  request  | in        | i_valid / o_ready  | req_type, pixel, vertices, points
//  result   | out       | o_valid / i_ready  | inside, origin x/y, flags
//
//  One transfer per cycle on each side unless the output stalls. A query
//  passes the table read, five geometry stages, the divider (an input stage,
//  then one quotient bit a stage) and the output register. A load gives no
//  result; it writes the table at its transfer, so a query in the next cycle
//  already sees it. Stalls hold the whole pipe; nothing is dropped or repeated.
//  Reset clears valid bits and the flag pipe only; the table holds garbage until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_inverse_warp #(
    parameter int NUM_LANDMARKS = tiw_pkg::TIW_NUM_LANDMARKS,
    parameter int FRAC_BITS     = tiw_pkg::TIW_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_req_type,
    input  wire logic [tiw_pkg::TIW_PIXW-1:0]  i_pixel_x,
    input  wire logic [tiw_pkg::TIW_PIXW-1:0]  i_pixel_y,
    input  wire logic [tiw_pkg::TIW_IDXW-1:0]  i_vertex_a,
    input  wire logic [tiw_pkg::TIW_IDXW-1:0]  i_vertex_b,
    input  wire logic [tiw_pkg::TIW_IDXW-1:0]  i_vertex_c,
    input  wire logic [tiw_pkg::TIW_CW-1:0]    i_warped_x,
    input  wire logic [tiw_pkg::TIW_CW-1:0]    i_warped_y,
    input  wire logic [tiw_pkg::TIW_CW-1:0]    i_source_x,
    input  wire logic [tiw_pkg::TIW_CW-1:0]    i_source_y,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_inside_res,
    output logic [tiw_pkg::TIW_PIXW-1:0]       o_origin_x,
    output logic [tiw_pkg::TIW_PIXW-1:0]       o_origin_y,
    output logic                               o_degenerate,
    output logic                               o_clamped
);
    import tiw_pkg::*;

    localparam int AW  = $clog2(NUM_LANDMARKS);
    localparam int PW  = TIW_PIXW + FRAC_BITS;
    localparam int BW  = tiw_max(PW, TIW_CW) + 1;
    localparam int NW  = TIW_DW + BW + 1;
    localparam int NXW = NW + TIW_DW + 2;

    logic r_out_valid;

    // whole pipe moves unless the output register is full and stalled
    logic adv, in_xfer;
    assign adv     = ~r_out_valid | i_ready;
    assign o_ready = adv;
    assign in_xfer = i_valid & adv;

    function automatic logic in_table(input logic [TIW_IDXW-1:0] idx);
        return (int'(idx) < NUM_LANDMARKS);
    endfunction

    // --- table: three copies, one read port each ---
    t_entry wdata;
    logic   we;
    assign wdata = '{wx: i_warped_x, wy: i_warped_y, sx: i_source_x, sy: i_source_y};
    assign we    = in_xfer & (i_req_type == TIW_REQ_LOAD) & in_table(i_vertex_a);

    t_entry rd_a, rd_b, rd_c;

    tiw_lmtab #(.NUM_LANDMARKS(NUM_LANDMARKS), .AW(AW)) u_tab_a (
        .i_clk(i_clk), .i_we(we), .i_waddr(AW'(i_vertex_a)), .i_wdata(wdata),
        .i_re(adv), .i_raddr(AW'(i_vertex_a)), .o_rdata(rd_a)
    );
    tiw_lmtab #(.NUM_LANDMARKS(NUM_LANDMARKS), .AW(AW)) u_tab_b (
        .i_clk(i_clk), .i_we(we), .i_waddr(AW'(i_vertex_a)), .i_wdata(wdata),
        .i_re(adv), .i_raddr(AW'(i_vertex_b)), .o_rdata(rd_b)
    );
    tiw_lmtab #(.NUM_LANDMARKS(NUM_LANDMARKS), .AW(AW)) u_tab_c (
        .i_clk(i_clk), .i_we(we), .i_waddr(AW'(i_vertex_a)), .i_wdata(wdata),
        .i_re(adv), .i_raddr(AW'(i_vertex_c)), .o_rdata(rd_c)
    );

    // --- stage 1: alongside the table read ---
    logic                r1_valid;
    logic [TIW_PIXW-1:0] r1_px, r1_py;
    logic                r1_ok_a, r1_ok_b, r1_ok_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= in_xfer & (i_req_type == TIW_REQ_QUERY);
        end
        if (adv) begin
            r1_px   <= i_pixel_x;
            r1_py   <= i_pixel_y;
            r1_ok_a <= in_table(i_vertex_a);
            r1_ok_b <= in_table(i_vertex_b);
            r1_ok_c <= in_table(i_vertex_c);
        end
    end

    // an index past the table reads as an all-zero entry
    t_entry ent_a, ent_b, ent_c;
    assign ent_a = r1_ok_a ? rd_a : '0;
    assign ent_b = r1_ok_b ? rd_b : '0;
    assign ent_c = r1_ok_c ? rd_c : '0;

    // --- stages 2..6: geometry ---
    logic signed [NXW-1:0]      g_nx, g_ny;
    logic signed [TIW_DETW-1:0] g_det;
    t_tag                       g_tag;

    tiw_geom #(.FRAC_BITS(FRAC_BITS), .PW(PW), .BW(BW), .NW(NW), .NXW(NXW)) u_geom (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r1_valid),
        .i_a(ent_a), .i_b(ent_b), .i_c(ent_c), .i_px(r1_px), .i_py(r1_py),
        .o_nx(g_nx), .o_ny(g_ny), .o_det(g_det), .o_tag(g_tag)
    );

    // --- divider stages, x and y side by side ---
    logic [TIW_PIXW-1:0] dx_coord, dy_coord;
    logic                dx_clip, dy_clip;

    tiw_div #(.FRAC_BITS(FRAC_BITS), .NXW(NXW)) u_div_x (
        .i_clk(i_clk), .i_en(adv), .i_num(g_nx), .i_det(g_det),
        .o_coord(dx_coord), .o_clip(dx_clip)
    );
    tiw_div #(.FRAC_BITS(FRAC_BITS), .NXW(NXW)) u_div_y (
        .i_clk(i_clk), .i_en(adv), .i_num(g_ny), .i_det(g_det),
        .o_coord(dy_coord), .o_clip(dy_clip)
    );

    // flags ride alongside the divider
    t_tag r_tag [TIW_DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIW_DIV_LAT; i++) begin
                r_tag[i] <= '0;
            end
        end else if (adv) begin
            r_tag[0] <= g_tag;
            for (int i = 1; i < TIW_DIV_LAT; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    // --- output register ---
    logic                r_inside, r_degen, r_clamped;
    logic [TIW_PIXW-1:0] r_ox, r_oy;
    t_tag                tag_end;
    assign tag_end = r_tag[TIW_DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tag_end.valid;
        end
        if (adv) begin
            r_inside <= tag_end.hit;
            r_degen  <= tag_end.degen;
            // degenerate triangle: no mapping
            if (tag_end.degen) begin
                r_ox      <= '0;
                r_oy      <= '0;
                r_clamped <= 1'b0;
            end else begin
                r_ox      <= dx_coord;
                r_oy      <= dy_coord;
                r_clamped <= dx_clip | dy_clip;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;
    assign o_origin_x   = r_ox;
    assign o_origin_y   = r_oy;
    assign o_degenerate = r_degen;
    assign o_clamped    = r_clamped;

    // --- assertions ---
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_origin_x == '0 && o_origin_y == '0 && !o_clamped)
        else $error("degenerate result carries a mapped coordinate");

    a_clamp_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clamped |-> (o_origin_x == '0 || o_origin_x == TIW_COORD_MAX ||
                                  o_origin_y == '0 || o_origin_y == TIW_COORD_MAX))
        else $error("clamp flag without a coordinate at the image border");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while the result register is stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire
